FILE: rtl/core/lbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

	localparam int FUNC_W   = 3;
	localparam int DEV_W    = 8;
	localparam int BLK_W    = 20;
	localparam int SLOT_W   = 5;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 8;
	localparam int LIMIT_W  = 21;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd2000;
	localparam logic [CNT_W-1:0]   CNT_MAX     = 8'hFF;

	// request function codes
	localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_PIN     = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_UNPIN   = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [DEV_W-1:0]  dev;
		logic [BLK_W-1:0]  block_number;
		logic [SLOT_W-1:0] slot;
	} lbc_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot_out;
		logic                hit;
		logic                disk_read;
		logic                disk_write;
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    ref_count;
	} lbc_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_SLOT,
		S_SWEEP,
		S_SWEEP_DRAIN,
		S_RESP
	} lbc_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/lbc_if.sv
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface lbc_req_if import lbc_pkg::*; ();
	logic     valid;
	logic     ready;
	lbc_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// result channel
interface lbc_rsp_if import lbc_pkg::*; ();
	logic     valid;
	logic     ready;
	lbc_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// block limit write channel
interface lbc_cfg_if import lbc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lbc_store.sv
`timescale 1ns / 1ps
`default_nettype none

module lbc_store #(
	parameter int DEPTH   = 32,
	parameter int ENTRY_W = 42
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [ENTRY_W-1:0]       wr_data,
	output logic      [ENTRY_W-1:0]       rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   written_q;
	logic [ENTRY_W-1:0] q_s1;
	logic               written_s1;
	logic [AW-1:0]      addr_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			q_s1    <= mem[rd_addr];
			addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			written_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				written_s1 <= written_q[rd_addr];
			end
		end
	end

	// untouched entry: all zero except the low field, which resets to the index
	assign rd_data = written_s1 ? q_s1 : ENTRY_W'(addr_s1);

endmodule

`default_nettype wire

FILE: rtl/core/lru_block_buffer_cache_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  beat                                             handshake
// req      in   func, dev, block_number, slot                    valid/ready
// rsp      out  slot_out, hit, disk_read, disk_write, status,    valid/ready
//               ref_count
// cfg      in   block_limit (21 bits)                            valid/ready, ready always high
//
// one request at a time; a new request is taken while the last beat waits on rsp.ready
// read: one pass over the memory read port finds the most recent tag match and the
// least recent free slot together; a rejected request skips the pass
// write, pin, unpin, release: one read of the named slot; release reaching zero adds a
// rank sweep over every entry, one read and write-back per cycle
// reset: async, active low; untouched entries read as their reset value, no clear pass
module lru_block_buffer_cache_core import lbc_pkg::*; #(
	parameter int NUM_SLOTS  = 32,
	parameter int BLOCK_BITS = 20
) (
	input wire logic clk,
	input wire logic arst_n,
	lbc_req_if.sink   req,
	lbc_rsp_if.source rsp,
	lbc_cfg_if.sink   cfg
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int TAG_W = BLOCK_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SLOTS - 1);

	// rank sits in the low bits so the store's reset value gives rank = index
	typedef struct packed {
		logic [DEV_W-1:0] dev;
		logic [TAG_W-1:0] tag;
		logic             vld;
		logic [CNT_W-1:0] cnt;
		logic [IDX_W-1:0] rank;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	lbc_state_t state_q, state_d;

	logic [LIMIT_W-1:0] limit_q;
	lbc_req_t           op_q;
	logic [IDX_W-1:0]   scan_q;

	// memory access
	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	entry_t           wr_data, rd_ent;
	logic [ENTRY_W-1:0] rd_raw;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	// scan trackers: best tag match and best free slot
	logic             m_found_q, f_found_q;
	logic [IDX_W-1:0] m_idx_q, f_idx_q;
	entry_t           m_ent_q, f_ent_q;

	// release sweep
	logic [IDX_W-1:0] r_rank_q;
	logic             sweep_go;

	// staged result and output register
	lbc_rsp_t res_q, res_d;
	logic     res_ld;
	logic     rsp_valid_q;
	lbc_rsp_t rsp_data_q;

	// derived values
	logic [31:0]      in_slot32, op_slot32, blk32, m_idx32, f_idx32;
	logic             in_range;
	logic [IDX_W-1:0] in_idx, op_idx;
	logic [TAG_W-1:0] tag_in;
	logic             scanning, sweeping;
	logic             take_m, take_f;
	logic [CNT_W-1:0] cnt_inc, cnt_dec, m_cnt_inc;

	assign in_slot32 = 32'(req.data.slot);
	assign in_range  = in_slot32 < NUM_SLOTS;
	assign in_idx    = in_slot32[IDX_W-1:0];
	assign op_slot32 = 32'(op_q.slot);
	assign op_idx    = op_slot32[IDX_W-1:0];
	assign blk32     = 32'(op_q.block_number);
	assign tag_in    = blk32[TAG_W-1:0];
	assign m_idx32   = 32'(m_idx_q);
	assign f_idx32   = 32'(f_idx_q);

	assign rd_ent    = entry_t'(rd_raw);
	assign cnt_inc   = (rd_ent.cnt == CNT_MAX) ? rd_ent.cnt : rd_ent.cnt + 8'd1;
	assign cnt_dec   = rd_ent.cnt - 8'd1;
	assign m_cnt_inc = (m_ent_q.cnt == CNT_MAX) ? m_ent_q.cnt : m_ent_q.cnt + 8'd1;

	assign scanning = (state_q == S_SCAN || state_q == S_DRAIN) && rd_vld_s1;
	assign sweeping = (state_q == S_SWEEP || state_q == S_SWEEP_DRAIN) && rd_vld_s1;

	// most recent match wins; least recent zero-count slot wins
	assign take_m = rd_ent.dev == op_q.dev && rd_ent.tag == tag_in &&
		(!m_found_q || rd_ent.rank > m_ent_q.rank);
	assign take_f = rd_ent.cnt == '0 && (!f_found_q || rd_ent.rank < f_ent_q.rank);

	lbc_store #(
		.DEPTH   (NUM_SLOTS),
		.ENTRY_W (ENTRY_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_raw)
	);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory control and result forming
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = scan_q;
		wr_en    = 1'b0;
		wr_addr  = op_idx;
		wr_data  = rd_ent;
		res_ld   = 1'b0;
		res_d    = '0;
		sweep_go = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					res_ld = 1'b1;
					unique case (req.data.func) inside
						FUNC_READ: begin
							if ({1'b0, req.data.block_number} >= limit_q) begin
								res_d.status = STATUS_RANGE;
								state_d      = S_RESP;
							end else begin
								state_d = S_SCAN;
							end
						end
						FUNC_WRITE, FUNC_RELEASE, FUNC_PIN, FUNC_UNPIN: begin
							res_d.slot_out = req.data.slot;
							if (!in_range) begin
								res_d.status = STATUS_UNDERFLOW;
								state_d      = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = in_idx;
								state_d = S_SLOT;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_SCAN: begin
				rd_en = 1'b1;
				if (scan_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				res_ld  = 1'b1;
				state_d = S_RESP;
				if (m_found_q) begin
					wr_en           = 1'b1;
					wr_addr         = m_idx_q;
					wr_data         = m_ent_q;
					wr_data.vld     = 1'b1;
					wr_data.cnt     = m_cnt_inc;
					res_d.slot_out  = m_idx32[SLOT_W-1:0];
					res_d.hit       = 1'b1;
					res_d.disk_read = !m_ent_q.vld;
					res_d.ref_count = m_cnt_inc;
				end else if (f_found_q) begin
					// claim: new tag, count one, always needs a fill
					wr_en           = 1'b1;
					wr_addr         = f_idx_q;
					wr_data         = f_ent_q;
					wr_data.dev     = op_q.dev;
					wr_data.tag     = tag_in;
					wr_data.vld     = 1'b1;
					wr_data.cnt     = 8'd1;
					res_d.slot_out  = f_idx32[SLOT_W-1:0];
					res_d.disk_read = 1'b1;
					res_d.ref_count = 8'd1;
				end else begin
					res_d.status = STATUS_FULL;
				end
			end
			S_SLOT: begin
				res_ld         = 1'b1;
				res_d.slot_out = op_q.slot;
				state_d        = S_RESP;
				if (op_q.func == FUNC_PIN) begin
					wr_en           = 1'b1;
					wr_data.cnt     = cnt_inc;
					res_d.ref_count = cnt_inc;
				end else if (rd_ent.cnt == '0) begin
					res_d.status = STATUS_UNDERFLOW;
				end else if (op_q.func == FUNC_WRITE) begin
					res_d.disk_write = 1'b1;
					res_d.ref_count  = rd_ent.cnt;
				end else begin
					wr_en           = 1'b1;
					wr_data.cnt     = cnt_dec;
					res_d.ref_count = cnt_dec;
					if (op_q.func == FUNC_RELEASE && cnt_dec == '0) begin
						sweep_go = 1'b1;
						state_d  = S_SWEEP;
					end
				end
			end
			S_SWEEP: begin
				rd_en = 1'b1;
				if (scan_q == LAST_IDX) begin
					state_d = S_SWEEP_DRAIN;
				end
			end
			S_SWEEP_DRAIN: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// rank sweep write-back trails the read by one entry
		if (sweeping) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1;
			wr_data = rd_ent;
			if (rd_idx_s1 == op_idx) begin
				wr_data.rank = LAST_IDX;
			end else if (rd_ent.rank > r_rank_q) begin
				wr_data.rank = rd_ent.rank - 1'b1;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			scan_q      <= '0;
			rd_vld_s1   <= 1'b0;
			m_found_q   <= 1'b0;
			f_found_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.data;
			end
			rd_vld_s1 <= rd_en;
			if (state_q == S_SCAN || state_q == S_SWEEP) begin
				scan_q <= (scan_q == LAST_IDX) ? '0 : scan_q + 1'b1;
			end
			if (state_q == S_IDLE && req.valid) begin
				m_found_q <= 1'b0;
				f_found_q <= 1'b0;
			end else if (scanning) begin
				if (take_m) begin
					m_found_q <= 1'b1;
				end
				if (take_f) begin
					f_found_q <= 1'b1;
				end
			end
			if (state_q == S_RESP && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			op_q <= req.data;
		end
		if (rd_en) begin
			rd_idx_s1 <= rd_addr;
		end
		if (scanning && take_m) begin
			m_idx_q <= rd_idx_s1;
			m_ent_q <= rd_ent;
		end
		if (scanning && take_f) begin
			f_idx_q <= rd_idx_s1;
			f_ent_q <= rd_ent;
		end
		if (sweep_go) begin
			r_rank_q <= rd_ent.rank;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (state_q == S_RESP && (!rsp_valid_q || rsp.ready)) begin
			rsp_data_q <= res_q;
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/lbc_checker.sv
`timescale 1ns / 1ps

module lbc_checker import lbc_pkg::*; #(
	parameter int NUM_SLOTS  = 32,
	parameter int BLOCK_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	lbc_req_if   req,
	lbc_rsp_if   rsp,
	lbc_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding
);

	localparam logic [BLK_W-1:0] TAG_MASK =
		(BLOCK_BITS >= BLK_W) ? '1 : BLK_W'((64'd1 << BLOCK_BITS) - 1);

	// shadow of the slot table
	logic [DEV_W-1:0]   dev_tag [NUM_SLOTS];
	logic [BLK_W-1:0]   blk_tag [NUM_SLOTS];
	logic               filled  [NUM_SLOTS];
	logic [CNT_W-1:0]   holders [NUM_SLOTS];
	int unsigned        recency [NUM_SLOTS];
	logic [LIMIT_W-1:0] block_limit;

	lbc_rsp_t due_rsp[$];
	lbc_rsp_t want;

	function automatic void clear_table();
		int i;
		for (i = 0; i < NUM_SLOTS; i++) begin
			dev_tag[i] = '0;
			blk_tag[i] = '0;
			filled[i]  = 1'b0;
			holders[i] = '0;
			recency[i] = i;
		end
		block_limit = LIMIT_RESET;
	endfunction

	function automatic void make_newest(input int s);
		int          i;
		int unsigned old;
		old = recency[s];
		for (i = 0; i < NUM_SLOTS; i++)
			if (recency[i] > old)
				recency[i]--;
		recency[s] = NUM_SLOTS - 1;
	endfunction

	// one request against the shadow table, returns the beat it must produce
	function automatic lbc_rsp_t cache_access(input lbc_req_t r);
		lbc_rsp_t o;
		int       pick;
		int       s;
		int       i;
		o    = '0;
		pick = -1;
		case (r.func) inside
			FUNC_READ: begin
				if (r.block_number >= block_limit) begin
					o.status = STATUS_RANGE;
				end else begin
					for (i = 0; i < NUM_SLOTS; i++)
						if (dev_tag[i] == r.dev && blk_tag[i] == (r.block_number & TAG_MASK) &&
							(pick < 0 || recency[i] > recency[pick]))
							pick = i;
					if (pick >= 0) begin
						o.hit = 1'b1;
						if (holders[pick] != CNT_MAX)
							holders[pick] = holders[pick] + 1'b1;
					end else begin
						for (i = 0; i < NUM_SLOTS; i++)
							if (holders[i] == '0 && (pick < 0 || recency[i] < recency[pick]))
								pick = i;
						if (pick < 0) begin
							o.status = STATUS_FULL;
						end else begin
							dev_tag[pick] = r.dev;
							blk_tag[pick] = r.block_number & TAG_MASK;
							filled[pick]  = 1'b0;
							holders[pick] = 8'd1;
						end
					end
					if (pick >= 0) begin
						if (!filled[pick]) begin
							o.disk_read  = 1'b1;
							filled[pick] = 1'b1;
						end
						o.slot_out  = SLOT_W'(pick);
						o.ref_count = holders[pick];
					end
				end
			end
			FUNC_WRITE, FUNC_RELEASE, FUNC_PIN, FUNC_UNPIN: begin
				s = int'(r.slot);
				o.slot_out = r.slot;
				if (s >= NUM_SLOTS) begin
					o.status = STATUS_UNDERFLOW;
				end else if (r.func == FUNC_PIN) begin
					if (holders[s] != CNT_MAX)
						holders[s] = holders[s] + 1'b1;
					o.ref_count = holders[s];
				end else if (holders[s] == '0) begin
					o.status = STATUS_UNDERFLOW;
				end else if (r.func == FUNC_WRITE) begin
					o.disk_write = 1'b1;
					o.ref_count  = holders[s];
				end else begin
					holders[s] = holders[s] - 1'b1;
					if (r.func == FUNC_RELEASE && holders[s] == '0)
						make_newest(s);
					o.ref_count = holders[s];
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic void report(input lbc_rsp_t exp_beat, input lbc_rsp_t got,
		input bit orphan);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan)
				$display("result beat with nothing due: slot %0d hit %0b rd %0b wr %0b %s",
					got.slot_out, got.hit, got.disk_read, got.disk_write,
					$sformatf("st %0d cnt %0d", got.status, got.ref_count));
			else
				$display("mismatch: exp slot %0d hit %0b rd %0b wr %0b st %0d cnt %0d",
					exp_beat.slot_out, exp_beat.hit, exp_beat.disk_read, exp_beat.disk_write,
					exp_beat.status, exp_beat.ref_count,
					" / got slot %0d hit %0b rd %0b wr %0b st %0d cnt %0d",
					got.slot_out, got.hit, got.disk_read, got.disk_write, got.status, got.ref_count);
		end
	endfunction

	initial begin
		mismatches  = 0;
		outstanding = 0;
		clear_table();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_table();
			due_rsp.delete();
			outstanding = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_rsp.size() == 0) begin
					report('0, rsp.data, 1'b1);
				end else begin
					want = due_rsp.pop_front();
					if (rsp.data.slot_out !== want.slot_out || rsp.data.hit !== want.hit ||
						rsp.data.disk_read !== want.disk_read ||
						rsp.data.disk_write !== want.disk_write ||
						rsp.data.status !== want.status || rsp.data.ref_count !== want.ref_count)
						report(want, rsp.data, 1'b0);
				end
			end
			if (cfg.valid && cfg.ready)
				block_limit = cfg.data;
			if (req.valid && req.ready)
				due_rsp.push_back(cache_access(req.data));
			outstanding = due_rsp.size();
		end
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb import lbc_pkg::*; ();

	localparam int NUM_SLOTS   = 32;
	localparam int BLOCK_BITS  = 20;
	localparam int QUIET_LIMIT = 4000;  // cycles without any beat before giving up
	localparam int HOLD_CYCLES = 300;   // long result-side hold-off
	localparam int TAIL_CYCLES = 64;    // beyond the slowest op
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 130;
	localparam int SAT_PINS    = 258;   // enough to pin past the count ceiling

	// result-side ready patterns
	typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic hold_rsp = 1'b0;
	int   mismatches;
	int   outstanding;
	int   cur_limit = int'(LIMIT_RESET);
	int   burst_left = 0;
	int   quiet_cycles = 0;
	int   held_slots[$];  // slots we believe carry a reference, steers stimulus only

	lbc_req_if req();
	lbc_rsp_if rsp();
	lbc_cfg_if cfg();

	lru_block_buffer_cache_core #(
		.NUM_SLOTS (NUM_SLOTS),
		.BLOCK_BITS(BLOCK_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	lbc_checker #(
		.NUM_SLOTS (NUM_SLOTS),
		.BLOCK_BITS(BLOCK_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic lbc_req_t mk_req(input logic [FUNC_W-1:0] f, input int dev, input int blk,
		input int slot);
		lbc_req_t r;
		r.func         = f;
		r.dev          = DEV_W'(dev);
		r.block_number = BLK_W'(blk);
		r.slot         = SLOT_W'(slot);
		return r;
	endfunction

	// pull a held slot out of the list (release / unpin drop a reference)
	function automatic logic [SLOT_W-1:0] take_held();
		int idx;
		int s;
		idx = $urandom_range(0, held_slots.size() - 1);
		s   = held_slots[idx];
		held_slots.delete(idx);
		return SLOT_W'(s);
	endfunction

	function automatic logic [SLOT_W-1:0] peek_held();
		return SLOT_W'(held_slots[$urandom_range(0, held_slots.size() - 1)]);
	endfunction

	// mostly well-formed get / use / release traffic on a small tag pool,
	// with some noise: random slots, out-of-range blocks, unused func codes
	function automatic lbc_req_t random_req();
		lbc_req_t r;
		int       roll;
		int       sel;
		int       top_blk;
		roll           = $urandom_range(0, 99);
		r.dev          = DEV_W'($urandom);
		r.block_number = BLK_W'($urandom);
		r.slot         = SLOT_W'($urandom);
		if (roll < 40) begin
			r.func = FUNC_READ;
			if ($urandom_range(0, 3) != 0)
				r.dev = DEV_W'($urandom_range(0, 3));
			top_blk = (cur_limit > 24) ? 23 : cur_limit - 1;
			sel     = $urandom_range(0, 9);
			if (sel < 7)
				r.block_number = BLK_W'($urandom_range(0, top_blk));
			else if (sel == 7)
				r.block_number = BLK_W'(cur_limit - 1);
			else if (sel == 8 && cur_limit < (1 << BLK_W))
				r.block_number = BLK_W'(cur_limit);  // first rejected block
		end else if (roll < 70) begin
			r.func = FUNC_RELEASE;
			if (held_slots.size() != 0 && $urandom_range(0, 6) != 0)
				r.slot = take_held();
		end else if (roll < 78) begin
			r.func = FUNC_WRITE;
			if (held_slots.size() != 0 && $urandom_range(0, 4) != 0)
				r.slot = peek_held();
		end else if (roll < 86) begin
			r.func = FUNC_PIN;
			if (held_slots.size() != 0 && $urandom_range(0, 9) < 7)
				r.slot = peek_held();
			held_slots.push_back(int'(r.slot));
		end else if (roll < 94) begin
			r.func = FUNC_UNPIN;
			if (held_slots.size() != 0 && $urandom_range(0, 9) < 7)
				r.slot = take_held();
		end else begin
			r.func = FUNC_W'($urandom_range(FUNC_UNPIN + 1, (1 << FUNC_W) - 1));
		end
		return r;
	endfunction

	// one request beat; called at a falling edge, returns at the falling edge after
	// acceptance with valid still high so back-to-back beats keep it up
	task automatic push_req(input lbc_req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req.data  <= item;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	// limit writes only with the block idle and every result back
	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		req.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		cfg.data  <= value;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		cur_limit = int'(value);
	endtask

	// learn which slots a good read handed out
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready && rsp.data.status == STATUS_OK &&
			(rsp.data.hit || rsp.data.disk_read))
			held_slots.push_back(int'(rsp.data.slot_out));
	end

	// result-side ready: shifting patterns, plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       tick;
		mode      = RX_OPEN;
		mode_left = 0;
		tick      = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_rsp) begin
				// hold off while the sender keeps offering, so the block backs up
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rsp = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(RX_OPEN, RX_PERIODIC));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					RX_OPEN:     rsp.ready <= 1'b1;
					RX_COIN:     rsp.ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY:   rsp.ready <= ($urandom_range(0, 4) != 0);
					RX_PERIODIC: rsp.ready <= ((tick % 4) != 3);
					default:     rsp.ready <= 1'b1;
				endcase
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
			(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int       f;
		int       phase;
		int       n;
		int       s;
		int       lim;
		arst_n    = 1'b0;
		req.valid = 1'b0;
		req.data  = '0;
		cfg.valid = 1'b0;
		cfg.data  = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, reset limit of 2000
		// reset tags are 0/0, so this matches the most recent empty slot and still fills
		push_req(mk_req(FUNC_READ, 0, 0, 0));
		push_req(mk_req(FUNC_READ, 0, 0, 0));              // plain hit, no fill
		push_req(mk_req(FUNC_READ, 8'hFF, 1999, 0));       // last legal block, miss
		push_req(mk_req(FUNC_READ, 1, 2000, 0));           // first rejected block
		push_req(mk_req(FUNC_READ, 8'hFF, 20'hFFFFF, 0));  // largest block number
		push_req(mk_req(FUNC_WRITE, 0, 0, 31));
		push_req(mk_req(FUNC_WRITE, 0, 0, 5));             // write of an unreferenced slot
		push_req(mk_req(FUNC_RELEASE, 0, 0, 31));
		push_req(mk_req(FUNC_RELEASE, 0, 0, 31));          // reaches zero, rank sweep
		push_req(mk_req(FUNC_RELEASE, 0, 0, 31));          // underflow
		push_req(mk_req(FUNC_PIN, 0, 0, 7));
		push_req(mk_req(FUNC_PIN, 0, 0, 7));
		push_req(mk_req(FUNC_UNPIN, 0, 0, 7));
		push_req(mk_req(FUNC_UNPIN, 0, 0, 7));
		push_req(mk_req(FUNC_UNPIN, 0, 0, 7));             // underflow
		for (f = FUNC_UNPIN + 1; f < (1 << FUNC_W); f++)
			push_req(mk_req(FUNC_W'(f), 8'hFF, 20'hFFFFF, 5'h1F));
		push_req(mk_req(FUNC_READ, 0, 0, 0));
		push_req(mk_req(FUNC_READ, 8'hFF, 1999, 0));
		push_req(mk_req(FUNC_RELEASE, 0, 0, 0));
		push_req(mk_req(FUNC_RELEASE, 0, 0, 0));
		push_req(mk_req(FUNC_WRITE, 0, 0, 0));

		// random phases, each under its own block limit
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       lim = 1;
				1:       lim = 1 << BLK_W;
				2:       lim = (1 << BLK_W) - 1;
				3:       lim = 24;
				5:       lim = int'(LIMIT_RESET);
				6:       lim = 300;
				default: lim = $urandom_range(1, 1 << BLK_W);
			endcase
			write_limit(LIMIT_W'(lim));

			if (phase == 3) begin
				// every slot referenced: misses find no free slot
				for (s = 0; s < NUM_SLOTS; s++)
					push_req(mk_req(FUNC_PIN, $urandom, $urandom, s));
				repeat (3)
					push_req(mk_req(FUNC_READ, $urandom, $urandom_range(0, cur_limit - 1), 0));
				for (s = 0; s < NUM_SLOTS; s++)
					push_req(mk_req(FUNC_UNPIN, $urandom, $urandom, s));
			end
			if (phase == 5) begin
				// drive one count into the ceiling and back down past zero
				s = $urandom_range(0, NUM_SLOTS - 1);
				repeat (SAT_PINS) push_req(mk_req(FUNC_PIN, $urandom, $urandom, s));
				push_req(mk_req(FUNC_WRITE, $urandom, $urandom, s));
				repeat (SAT_PINS) push_req(mk_req(FUNC_UNPIN, $urandom, $urandom, s));
			end

			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 2 && n == 20)
					hold_rsp = 1'b1;
				push_req(random_req());
			end
		end

		// drain, then let the slowest op finish
		req.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/lbc_pkg.sv
rtl/core/lbc_if.sv
rtl/core/lbc_store.sv
rtl/core/lru_block_buffer_cache_core.sv
tb/sv/lbc_checker.sv
tb/sv/tb.sv
